@@ src/srsa_pkg.sv @@
`timescale 1ns / 1ps

package srsa_pkg;

    // operation codes of the input word
    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    // status codes of the result word
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_SPACE = 2'd1;
    localparam logic [1:0] STAT_BAD_FREE = 2'd2;

    localparam int          CFG_W         = 4;
    localparam int          OFFSET_W      = 12;
    localparam int          USED_W        = 10;
    localparam int          SLOT_W        = 9;
    localparam logic [3:0]  MAX_SLOT_LOG2 = 4'd8;
    localparam logic [3:0]  CFG_RESET     = 4'd3;
    localparam logic [9:0]  USED_MAX      = 10'd1023;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    // command from the sequencer to the occupancy map
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_bit;
        logic clear;
    } t_occ_cmd;

endpackage

@@ src/srsa_occ_map.sv @@
`timescale 1ns / 1ps

module srsa_occ_map #(
    parameter int GRANULES = 512
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  srsa_pkg::t_occ_cmd          i_cmd,
    input  logic [$clog2(GRANULES)-1:0] i_addr,
    output logic                        o_rd_bit,
    output logic                        o_busy
);

    localparam int GW = $clog2(GRANULES);
    localparam logic [GW-1:0] LAST = GW'(GRANULES - 1);

    logic          r_mem [GRANULES];
    logic          r_rd_bit;
    logic          r_clr_busy;
    logic [GW-1:0] r_clr_addr;

    // clearing sweep after reset and on init
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LAST) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // single write port, sweep has priority
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= 1'b0;
        end else if (i_cmd.wr_en) begin
            r_mem[i_addr] <= i_cmd.wr_bit;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_bit <= r_mem[i_addr];
        end
    end

    assign o_rd_bit = r_rd_bit;
    assign o_busy   = r_clr_busy;

endmodule

@@ src/slab_run_slot_allocator.sv @@
`timescale 1ns / 1ps

// Slot allocator for one run of RUN_BYTES bytes split into equal power-of-two slots.
// A word is accepted in S_IDLE, which reads the occupancy memory and the free-list
// link memory; S_EXEC then writes back and loads the result register, and waits
// while the result register is still held by the consumer. A new word is accepted
// only back in S_IDLE, but while a finished result waits. After reset and after every
// init the occupancy memory is swept clear, one entry a cycle, over all
// RUN_BYTES >> MIN_SLOT_LOG2 entries (512 at the defaults); no word is accepted during
// the sweep, while configuration writes are always taken. The slot size register value
// is clamped to MIN_SLOT_LOG2..8 when used and should change only right before an init.
module slab_run_slot_allocator #(
    parameter int RUN_BYTES     = 4096,
    parameter int MIN_SLOT_LOG2 = 3,
    parameter int HEADER_BYTES  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [11:0] i_offset,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [11:0] o_slot_offset,
    output logic        o_live,
    output logic [9:0]  o_used_count
);

    localparam int AW       = $clog2(RUN_BYTES);
    localparam int GRANULES = RUN_BYTES >> MIN_SLOT_LOG2;
    localparam int GW       = $clog2(GRANULES);
    localparam int WW       = $clog2(RUN_BYTES + HEADER_BYTES + 512) + 1;
    localparam logic [3:0] MIN_L2 = 4'(MIN_SLOT_LOG2);
    localparam int SLOT_W_L = srsa_pkg::SLOT_W;

    srsa_pkg::t_state   r_state;
    srsa_pkg::t_occ_cmd occ_cmd;

    logic [3:0]    r_cfg;
    logic [1:0]    r_op;
    logic [11:0]   r_offset;
    logic [GW-1:0] r_head;
    logic          r_nonempty;
    logic [GW:0]   r_free_cnt;
    logic [AW-1:0] r_bump;
    logic [9:0]    r_used;
    logic [GW-1:0] r_link_mem [GRANULES];
    logic [GW-1:0] r_link_rd;

    logic          r_out_valid;
    logic [1:0]    r_status;
    logic [11:0]   r_slot_off;
    logic          r_live;
    logic [9:0]    r_used_out;

    logic          in_accept;
    logic          exec_go;
    logic          occ_busy;
    logic          occ_rd_bit;
    logic [GW-1:0] occ_addr;
    logic [GW-1:0] in_gran;
    logic [AW-1:0] tail;
    logic [3:0]    eff_l2;
    logic [SLOT_W_L-1:0] slot;

    logic [WW-1:0] first_off;
    logic [WW-1:0] bump_sum;

    logic [GW-1:0] n_head;
    logic          n_nonempty;
    logic [GW:0]   n_free_cnt;
    logic [AW-1:0] n_bump;
    logic [9:0]    n_used;
    logic [1:0]    n_status;
    logic [11:0]   n_slot_off;
    logic          n_live;
    logic [GW-1:0] exec_gran;
    logic          occ_wr;
    logic          occ_wr_bit;
    logic          link_wr;

    // configuration register, always ready
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= srsa_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    // effective slot size
    always_comb begin
        if (r_cfg < MIN_L2) begin
            eff_l2 = MIN_L2;
        end else if (r_cfg > srsa_pkg::MAX_SLOT_LOG2) begin
            eff_l2 = srsa_pkg::MAX_SLOT_LOG2;
        end else begin
            eff_l2 = r_cfg;
        end
    end
    assign slot = SLOT_W_L'(1) << eff_l2;

    // handshake
    assign o_in_ready = (r_state == srsa_pkg::S_IDLE) && !occ_busy;
    assign in_accept  = i_in_valid && o_in_ready;
    assign exec_go    = (r_state == srsa_pkg::S_EXEC) && (!r_out_valid || i_out_ready);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srsa_pkg::S_IDLE;
        end else if (in_accept) begin
            r_state <= srsa_pkg::S_EXEC;
        end else if (exec_go) begin
            r_state <= srsa_pkg::S_IDLE;
        end
    end

    // capture the accepted word
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op     <= i_op;
            r_offset <= i_offset;
        end
    end

    // granule of the incoming offset, used for the occupancy read
    assign in_gran = GW'(AW'(i_offset) >> MIN_SLOT_LOG2);

    // offset of the word at work
    assign tail = AW'(r_offset);

    // first slot offset after the header
    assign first_off = (WW'(HEADER_BYTES) + WW'(slot) - WW'(1))
                       & ~(WW'(slot) - WW'(1));
    assign bump_sum  = WW'(r_bump) + WW'(slot);

    // read-modify-write of the state
    always_comb begin
        n_head     = r_head;
        n_nonempty = r_nonempty;
        n_free_cnt = r_free_cnt;
        n_bump     = r_bump;
        n_used     = r_used;
        n_status   = srsa_pkg::STAT_OK;
        n_slot_off = '0;
        n_live     = 1'b0;
        exec_gran  = tail[AW-1:MIN_SLOT_LOG2];
        occ_wr     = 1'b0;
        occ_wr_bit = 1'b0;
        link_wr    = 1'b0;
        case (srsa_pkg::t_op'(r_op))
            srsa_pkg::OP_INIT: begin
                n_bump     = (first_off >= WW'(RUN_BYTES)) ? '0 : AW'(first_off);
                n_head     = '0;
                n_nonempty = 1'b0;
                n_free_cnt = '0;
                n_used     = '0;
            end
            srsa_pkg::OP_ALLOC: begin
                if (r_nonempty) begin
                    exec_gran  = r_head;
                    n_head     = r_link_rd;
                    n_free_cnt = r_free_cnt - 1'b1;
                    n_nonempty = (r_free_cnt != (GW+1)'(1));
                    occ_wr     = 1'b1;
                end else if (r_bump != '0) begin
                    exec_gran  = r_bump[AW-1:MIN_SLOT_LOG2];
                    n_bump     = (bump_sum >= WW'(RUN_BYTES)) ? '0 : AW'(bump_sum);
                    occ_wr     = 1'b1;
                end else begin
                    n_status   = srsa_pkg::STAT_NO_SPACE;
                end
                if (occ_wr) begin
                    occ_wr_bit = 1'b1;
                    n_slot_off = 12'({exec_gran, {MIN_SLOT_LOG2{1'b0}}});
                    if (r_used < srsa_pkg::USED_MAX) begin
                        n_used = r_used + 1'b1;
                    end
                end
            end
            srsa_pkg::OP_FREE: begin
                if (!occ_rd_bit) begin
                    n_status = srsa_pkg::STAT_BAD_FREE;
                end else begin
                    link_wr    = 1'b1;
                    n_head     = exec_gran;
                    n_free_cnt = r_free_cnt + 1'b1;
                    n_nonempty = 1'b1;
                    occ_wr     = 1'b1;
                    occ_wr_bit = 1'b0;
                    if (r_used != '0) begin
                        n_used = r_used - 1'b1;
                    end
                end
            end
            srsa_pkg::OP_QUERY: begin
                if ((WW'(tail) & (WW'(slot) - WW'(1))) == '0) begin
                    n_live = occ_rd_bit;
                end
            end
            default: begin
                n_status = srsa_pkg::STAT_OK;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_nonempty <= 1'b0;
            r_free_cnt <= '0;
            r_bump     <= '0;
            r_used     <= '0;
        end else if (exec_go) begin
            r_head     <= n_head;
            r_nonempty <= n_nonempty;
            r_free_cnt <= n_free_cnt;
            r_bump     <= n_bump;
            r_used     <= n_used;
        end
    end

    // free-list link memory
    always_ff @(posedge i_clk) begin
        if (exec_go && link_wr) begin
            r_link_mem[exec_gran] <= r_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_link_rd <= r_link_mem[r_head];
        end
    end

    // occupancy map
    assign occ_addr       = in_accept ? in_gran : exec_gran;
    assign occ_cmd.rd_en  = in_accept;
    assign occ_cmd.wr_en  = exec_go && occ_wr;
    assign occ_cmd.wr_bit = occ_wr_bit;
    assign occ_cmd.clear  = exec_go && (srsa_pkg::t_op'(r_op) == srsa_pkg::OP_INIT);

    srsa_occ_map #(
        .GRANULES (GRANULES)
    ) u_occ_map (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (occ_cmd),
        .i_addr   (occ_addr),
        .o_rd_bit (occ_rd_bit),
        .o_busy   (occ_busy)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_status   <= n_status;
            r_slot_off <= n_slot_off;
            r_live     <= n_live;
            r_used_out <= n_used;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_slot_offset = r_slot_off;
    assign o_live        = r_live;
    assign o_used_count  = r_used_out;

endmodule

@@ src/srsa_checker.sv @@
`timescale 1ns / 1ps

module srsa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic [11:0] o_slot_offset,
    input logic        o_live,
    input logic [9:0]  o_used_count
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
        && $stable(o_slot_offset) && $stable(o_live) && $stable(o_used_count))
        else $error("result word changed while stalled");

    // status is one of the defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == srsa_pkg::STAT_OK)
        || (o_status == srsa_pkg::STAT_NO_SPACE)
        || (o_status == srsa_pkg::STAT_BAD_FREE))
        else $error("undefined status code");

    // failed operations report no slot and no live bit
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != srsa_pkg::STAT_OK)
        |-> (o_slot_offset == '0) && !o_live)
        else $error("failed operation carries a slot or live bit");

    // a live answer never comes with a slot offset
    a_live_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_live |-> (o_slot_offset == '0))
        else $error("live answer with slot offset");

    // one word at a time: no accept right after an accept
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after an accept");

endmodule

bind slab_run_slot_allocator srsa_checker u_srsa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_slot_offset (o_slot_offset),
    .o_live        (o_live),
    .o_used_count  (o_used_count)
);

@@ sim/slab_run_slot_allocator_chk.sv @@
`timescale 1ns / 1ps

module slab_run_slot_allocator_chk (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic          i_cfg_ready,
    input  logic [3:0]    i_cfg_data,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  srsa_pkg::t_op i_op,
    input  logic [11:0]   i_offset,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  logic [1:0]    i_status,
    input  logic [11:0]   i_slot_offset,
    input  logic          i_live,
    input  logic [9:0]    i_used_count,
    output int            o_fail_count,
    output int            o_pending
);

    localparam int RUN_BYTES     = 4096;
    localparam int MIN_SLOT_LOG2 = 3;
    localparam int HEADER_BYTES  = 64;
    localparam int GRANULES      = RUN_BYTES >> MIN_SLOT_LOG2;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] slot_offset;
        logic        live;
        logic [9:0]  used_count;
    } t_slot_word;

    // shadow of the allocator state
    logic                        occ_map [GRANULES];
    logic [srsa_pkg::SLOT_W-1:0] next_link [GRANULES];
    logic [srsa_pkg::SLOT_W-1:0] list_head;
    logic                        list_nonempty;
    int unsigned                 list_len;
    logic [12:0]                 bump_ptr;
    logic [srsa_pkg::USED_W-1:0] used_slots;
    logic [srsa_pkg::CFG_W-1:0]  slot_size_reg;

    t_slot_word         expected_words [$];
    int                 mismatches = 0;

    assign o_fail_count = mismatches;

    // apply one word to the shadow state and work out its result word
    task automatic predict_slot_word(input srsa_pkg::t_op op, input logic [11:0] off,
                                     output t_slot_word word);
        int unsigned size_log2;
        int unsigned slot;
        int unsigned first;
        int unsigned g;
        int unsigned nxt;
        logic        got;
        word      = '0;
        size_log2 = slot_size_reg;
        if (size_log2 < MIN_SLOT_LOG2) size_log2 = MIN_SLOT_LOG2;
        if (size_log2 > srsa_pkg::MAX_SLOT_LOG2) size_log2 = srsa_pkg::MAX_SLOT_LOG2;
        slot = 1 << size_log2;
        case (op)
            srsa_pkg::OP_INIT: begin
                // header rounded up to whole slots; a full run starts exhausted
                first = ((HEADER_BYTES + slot - 1) / slot) * slot;
                bump_ptr      = (first >= RUN_BYTES) ? '0 : 13'(first);
                list_head     = '0;
                list_nonempty = 1'b0;
                list_len      = 0;
                used_slots    = '0;
                foreach (occ_map[i]) occ_map[i] = 1'b0;
            end
            srsa_pkg::OP_ALLOC: begin
                // free list first, then the bump pointer
                got = 1'b1;
                g   = 0;
                if (list_nonempty) begin
                    g             = list_head;
                    list_head     = next_link[g];
                    list_len      = list_len - 1;
                    list_nonempty = (list_len != 0);
                end else if (bump_ptr != 0) begin
                    g        = (int'(bump_ptr) & (RUN_BYTES - 1)) >> MIN_SLOT_LOG2;
                    nxt      = int'(bump_ptr) + slot;
                    bump_ptr = (nxt >= RUN_BYTES) ? '0 : 13'(nxt);
                end else begin
                    got = 1'b0;
                end
                if (got) begin
                    occ_map[g] = 1'b1;
                    if (used_slots < srsa_pkg::USED_MAX) used_slots = used_slots + 1'b1;
                    word.slot_offset = 12'(g << MIN_SLOT_LOG2);
                end else begin
                    word.status = srsa_pkg::STAT_NO_SPACE;
                end
            end
            srsa_pkg::OP_FREE: begin
                // no alignment check, only the granule of the offset is looked at
                g = off >> MIN_SLOT_LOG2;
                if (!occ_map[g]) begin
                    word.status = srsa_pkg::STAT_BAD_FREE;
                end else begin
                    next_link[g]  = list_head;
                    list_head     = srsa_pkg::SLOT_W'(g);
                    list_len      = list_len + 1;
                    list_nonempty = 1'b1;
                    occ_map[g]    = 1'b0;
                    if (used_slots > 0) used_slots = used_slots - 1'b1;
                end
            end
            default: begin
                // unaligned queries never report live
                if ((int'(off) & (slot - 1)) == 0)
                    word.live = occ_map[off >> MIN_SLOT_LOG2];
            end
        endcase
        word.used_count = used_slots;
    endtask

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
        end
    endtask

    // watch the three channels
    always @(posedge i_clk) begin : watch
        t_slot_word want;
        if (!i_rst_n) begin
            foreach (occ_map[i]) occ_map[i] = 1'b0;
            list_head     = '0;
            list_nonempty = 1'b0;
            list_len      = 0;
            bump_ptr      = '0;
            used_slots    = '0;
            slot_size_reg = srsa_pkg::CFG_RESET;
            expected_words.delete();
        end else begin
            // compare the result word with the oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result word with none expected, expected none, %s %0d %0d %0d %0d",
                             $time, "actual", i_status, i_slot_offset, i_live,
                             i_used_count);
                end else begin
                    want = expected_words.pop_front();
                    check_field("status", want.status, i_status);
                    check_field("slot_offset", want.slot_offset, i_slot_offset);
                    check_field("live", want.live, i_live);
                    check_field("used_count", want.used_count, i_used_count);
                end
            end
            if (i_cfg_valid && i_cfg_ready) slot_size_reg = i_cfg_data;
            if (i_in_valid && i_in_ready) begin
                predict_slot_word(i_op, i_offset, want);
                expected_words.push_back(want);
            end
        end
        o_pending <= expected_words.size();
    end

endmodule

@@ sim/slab_run_slot_allocator_tb.sv @@
`timescale 1ns / 1ps

module slab_run_slot_allocator_tb;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          cfg_valid = 1'b0;
    logic [3:0]    cfg_data  = '0;
    logic          in_valid  = 1'b0;
    srsa_pkg::t_op in_op     = srsa_pkg::OP_INIT;
    logic [11:0]   in_offset = '0;
    logic          out_ready = 1'b1;

    logic        cfg_ready;
    logic        in_ready;
    logic        out_valid;
    logic [1:0]  status;
    logic [11:0] slot_offset;
    logic        live;
    logic [9:0]  used_count;
    int          fail_count;
    int          pending;

    logic        idle_on = 1'b1;
    logic [11:0] live_slots [$];
    logic [11:0] last_freed = '0;

    // clock
    always #6 clk = ~clk;

    slab_run_slot_allocator uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_op          (in_op),
        .i_offset      (in_offset),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_status      (status),
        .o_slot_offset (slot_offset),
        .o_live        (live),
        .o_used_count  (used_count)
    );

    slab_run_slot_allocator_chk checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_op          (in_op),
        .i_offset      (in_offset),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_status      (status),
        .i_slot_offset (slot_offset),
        .i_live        (live),
        .i_used_count  (used_count),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // result side back-pressure
    always @(posedge clk) begin
        if (idle_on) out_ready <= ($urandom_range(99) >= 7);
        else out_ready <= 1'b1;
    end

    // collect allocated offsets on the falling edge, ahead of the accepting rising edge
    always @(negedge clk) begin
        if (out_valid && out_ready && slot_offset != 0) live_slots.push_back(slot_offset);
    end

    // one input word, with an optional random gap first
    task automatic send_word(input srsa_pkg::t_op op, input logic [11:0] off);
        if (idle_on) begin
            while ($urandom_range(99) < 7) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        in_op     <= op;
        in_offset <= off;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // stop sending and wait for every outstanding result word
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // one setting of the slot size, an init, then a random mix of words
    task automatic run_phase(input logic [3:0] size_code, input int n_items, input int alloc_w);
        int          r;
        int          pick;
        int          idx;
        logic [11:0] off;
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= size_code;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        live_slots.delete();
        send_word(srsa_pkg::OP_INIT, 12'($urandom));
        repeat (n_items) begin
            r    = $urandom_range(99);
            pick = $urandom_range(99);
            off  = 12'($urandom);
            if (r < 2) begin
                live_slots.delete();
                send_word(srsa_pkg::OP_INIT, off);
            end else if (r < 2 + alloc_w) begin
                send_word(srsa_pkg::OP_ALLOC, off);
            end else if (r < 2 + alloc_w + (98 - alloc_w) * 6 / 10) begin
                // mostly frees of live slots, some double frees and noise
                if (live_slots.size() != 0 && pick < 75) begin
                    idx = $urandom_range(live_slots.size() - 1);
                    off = live_slots[idx];
                    live_slots.delete(idx);
                    last_freed = off;
                end else if (pick < 88) begin
                    off = last_freed;
                end
                send_word(srsa_pkg::OP_FREE, off);
            end else begin
                // queries of live slots, nudged live slots, aligned and raw offsets
                if (live_slots.size() != 0 && pick < 50) begin
                    off = live_slots[$urandom_range(live_slots.size() - 1)];
                    if (pick < 15) off = off + 12'($urandom_range(7));
                end else if (pick < 80) begin
                    off = off & ~((12'd1 << $urandom_range(8, 3)) - 12'd1);
                end
                send_word(srsa_pkg::OP_QUERY, off);
            end
        end
    endtask

    initial begin : stimulus
        logic [3:0] sizes [11];
        sizes = '{4'd15, 4'd0, 4'd8, 4'd3, 4'd7, 4'd2, 4'd9, 4'd6, 4'd5, 4'd4, 4'd3};
        sizes[10] = 4'($urandom_range(15));
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // before any init: no space, bad free, not live
        send_word(srsa_pkg::OP_ALLOC, 12'hfff);
        send_word(srsa_pkg::OP_FREE, 12'h000);
        send_word(srsa_pkg::OP_QUERY, 12'h000);
        // at the reset slot size of 8 bytes
        send_word(srsa_pkg::OP_INIT, 12'hfff);
        send_word(srsa_pkg::OP_ALLOC, 12'h000);
        send_word(srsa_pkg::OP_ALLOC, 12'hfff);
        send_word(srsa_pkg::OP_QUERY, 12'd64);
        send_word(srsa_pkg::OP_QUERY, 12'd68);
        send_word(srsa_pkg::OP_QUERY, 12'hfff);
        send_word(srsa_pkg::OP_FREE, 12'd64);
        send_word(srsa_pkg::OP_FREE, 12'd64);
        send_word(srsa_pkg::OP_FREE, 12'hfff);
        send_word(srsa_pkg::OP_ALLOC, 12'h000);
        // lifo order of the free list, then back to the bump pointer
        send_word(srsa_pkg::OP_FREE, 12'd72);
        send_word(srsa_pkg::OP_FREE, 12'd64);
        send_word(srsa_pkg::OP_ALLOC, 12'h000);
        send_word(srsa_pkg::OP_ALLOC, 12'h000);
        send_word(srsa_pkg::OP_ALLOC, 12'h000);
        send_word(srsa_pkg::OP_QUERY, 12'h000);

        // random phases over clamped and in-range slot sizes
        for (int p = 0; p < 11; p++) begin
            idle_on = (p != 3);
            run_phase(sizes[p], 65, (sizes[p] >= 4'd7) ? 60 : $urandom_range(40, 65));
        end
        idle_on = 1'b1;

        drain_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

    // run time limit
    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
